/* sv/plbe_pkg.sv */
// Shared types and constants for the parallel LED bit-cell encoder.
package plbe_pkg;

  localparam int BYTE_W      = 8;
  localparam int CELL_STEPS  = 4;
  localparam int CELL_W      = BYTE_W * CELL_STEPS;
  localparam int CELLS_W     = 20;
  localparam int PERIOD_W    = 16;
  localparam int LATCH_US_W  = 10;
  localparam int DIVISOR_W   = PERIOD_W + 1;
  localparam int US_TO_NS    = 1000;
  localparam int DIV_STEPS   = CELLS_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int BITS_PER_CELL_ITEM = 8;
  localparam int BIT_IDX_W   = $clog2(BITS_PER_CELL_ITEM);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LANE_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_MASK   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD_NS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_US      = 2'd3;

  localparam logic [BYTE_W-1:0]     LANE_ENABLE_RST   = 8'd0;
  localparam logic [BYTE_W-1:0]     INVERT_MASK_RST   = 8'd0;
  localparam logic [PERIOD_W-1:0]   BIT_PERIOD_RST    = 16'd1250;
  localparam logic [LATCH_US_W-1:0] LATCH_US_RST      = 10'd300;

  typedef struct packed {
    logic               ready;
    logic [CELLS_W-1:0] cells;
  } div_status_t;

endpackage

/* sv/plbe_queue.sv */
// Small register queue between the classifying front and the expanding back.
module plbe_queue #(
  parameter int WIDTH = 73,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/plbe_front.sv */
// Input stage: accepts items, masks lanes and drops data items with no active lane.
module plbe_front #(
  parameter int LANES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          command,
  input  logic [63:0]                   lane_bytes,
  input  logic [7:0]                    lane_valid,
  input  logic [7:0]                    lane_enable,
  output logic                          q_wr,
  output logic [LANES*9:0]              q_data,
  input  logic                          q_full
);

  logic                   stage_valid;
  logic                   stage_eof;
  logic [LANES-1:0]       stage_mask;
  logic [LANES*8-1:0]     stage_bytes;
  logic                   accept;
  logic                   keep;
  logic [LANES-1:0]       in_mask;

  assign in_mask = lane_valid[LANES-1:0] & lane_enable[LANES-1:0];
  assign keep    = command || (in_mask != '0);
  assign full    = stage_valid && q_full;
  assign accept  = push && !full;
  assign q_wr    = stage_valid && !q_full;
  assign q_data  = {stage_eof, stage_mask, stage_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept && keep) begin
      stage_valid <= 1'b1;
    end else if (q_wr) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      stage_eof   <= command;
      stage_mask  <= in_mask;
      stage_bytes <= lane_bytes[LANES*8-1:0];
    end
  end

endmodule

/* sv/plbe_div.sv */
// Restoring divider for the reset gap length, rerun after reset and timing writes.
module plbe_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 restart,
  input  logic [plbe_pkg::PERIOD_W-1:0]        bit_period_ns,
  input  logic [plbe_pkg::LATCH_US_W-1:0]      latch_us,
  output plbe_pkg::div_status_t                status
);

  localparam int CW = plbe_pkg::CELLS_W;
  localparam int DW = plbe_pkg::DIVISOR_W;

  logic                              pending;
  logic                              running;
  logic [plbe_pkg::DIV_CNT_W-1:0]    steps;
  logic [CW-1:0]                     quo;
  logic [DW-1:0]                     rem;
  logic [DW-1:0]                     divisor;
  logic [DW:0]                       trial;
  logic [DW:0]                       diff;
  logic                              take;

  assign trial = {rem, quo[CW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  assign status.ready = !pending && !running;
  assign status.cells = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b1;
      running <= 1'b0;
      steps   <= '0;
    end else if (restart) begin
      pending <= 1'b1;
      running <= 1'b0;
    end else if (pending) begin
      pending <= 1'b0;
      running <= 1'b1;
      steps   <= plbe_pkg::DIV_CNT_W'(plbe_pkg::DIV_STEPS);
    end else if (running) begin
      steps <= steps - 1'b1;
      if (steps == plbe_pkg::DIV_CNT_W'(1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      quo     <= CW'(latch_us) * CW'(plbe_pkg::US_TO_NS);
      rem     <= '0;
      divisor <= DW'(bit_period_ns) + DW'(1);
    end else if (running) begin
      rem <= take ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[CW-2:0], take};
    end
  end

endmodule

/* sv/plbe_back.sv */
// Output stage: expands queued items into bit-cell words or one reset-gap result.
module plbe_back #(
  parameter int LANES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  logic [LANES*9:0]                    q_data,
  output logic                                q_rd,
  input  logic [7:0]                          invert_mask,
  input  plbe_pkg::div_status_t               div_status,
  output logic                                empty,
  input  logic                                pop,
  output logic [plbe_pkg::CELL_W-1:0]         cell_word,
  output logic                                is_reset,
  output logic [plbe_pkg::CELLS_W-1:0]        reset_cells,
  output logic                                last
);

  logic                              out_valid;
  logic [plbe_pkg::BIT_IDX_W-1:0]    bit_idx;
  logic                              head_eof;
  logic [LANES-1:0]                  head_mask;
  logic [LANES*8-1:0]                head_bytes;
  logic                              load;
  logic                              final_bit;
  logic [LANES-1:0]                  ones;
  logic [2:0]                        sel;
  logic [7:0]                        mask8;
  logic [7:0]                        ones8;
  logic [plbe_pkg::CELL_W-1:0]       inv_word;

  assign {head_eof, head_mask, head_bytes} = q_data;
  assign empty     = !out_valid;
  assign load      = q_valid && (!out_valid || pop) && (!head_eof || div_status.ready);
  assign final_bit = (bit_idx == plbe_pkg::BIT_IDX_W'(plbe_pkg::BITS_PER_CELL_ITEM - 1));
  assign q_rd      = load && (head_eof || final_bit);
  assign sel       = 3'(7) - 3'(bit_idx);
  assign inv_word  = {4{invert_mask}};
  assign mask8     = 8'(head_mask);
  assign ones8     = 8'(ones);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ones[k] = head_mask[k] && head_bytes[8*k + sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bit_idx   <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load && !head_eof) begin
        bit_idx <= bit_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head_eof) begin
        cell_word   <= inv_word;
        is_reset    <= 1'b1;
        reset_cells <= div_status.cells;
        last        <= 1'b1;
      end else begin
        cell_word   <= {8'd0, ones8, ones8, mask8} ^ inv_word;
        is_reset    <= 1'b0;
        reset_cells <= '0;
        last        <= final_bit;
      end
    end
  end

endmodule

/* sv/parallel_led_bit_cell_encoder_unit.sv */
// Top level of the parallel LED bit-cell encoder.
//
//   Channel   Signals                                    Handshake
//   input     command, lane_bytes, lane_valid            push / full
//   result    cell_word, is_reset, reset_cells, last     empty / pop
//   config    cfg_index, cfg_data                        cfg_valid / cfg_ready
//
// A data item with any active lane yields eight results, one per cycle while pop
// is high, so the back stage sets the sustained rate of data items.
// An end-of-frame item yields one result once the gap divider is done.
// The gap divider reruns after reset and after each write of bit_period_ns or
// latch_us; an end-of-frame item waits at the back stage until it is done.
// The front register and a two-entry queue keep items flowing while pop is low.
module parallel_led_bit_cell_encoder_unit #(
  parameter int LANES       = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 command,
  input  logic [63:0]                          lane_bytes,
  input  logic [7:0]                           lane_valid,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [plbe_pkg::CELL_W-1:0]          cell_word,
  output logic                                 is_reset,
  output logic [plbe_pkg::CELLS_W-1:0]         reset_cells,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [plbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [plbe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ENTRY_W = LANES * 9 + 1;

  logic [7:0]                          lane_enable;
  logic [7:0]                          invert_mask;
  logic [plbe_pkg::PERIOD_W-1:0]       bit_period_ns;
  logic [plbe_pkg::LATCH_US_W-1:0]     latch_us;
  logic                                cfg_wr;
  logic                                div_restart;
  plbe_pkg::div_status_t               div_status;
  logic                                q_wr;
  logic [ENTRY_W-1:0]                  q_wr_data;
  logic                                q_full;
  logic                                q_rd;
  logic                                q_valid;
  logic [ENTRY_W-1:0]                  q_rd_data;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign div_restart = cfg_wr && ((cfg_index == plbe_pkg::REG_BIT_PERIOD_NS) ||
                                  (cfg_index == plbe_pkg::REG_LATCH_US));

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_enable   <= plbe_pkg::LANE_ENABLE_RST;
      invert_mask   <= plbe_pkg::INVERT_MASK_RST;
      bit_period_ns <= plbe_pkg::BIT_PERIOD_RST;
      latch_us      <= plbe_pkg::LATCH_US_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        plbe_pkg::REG_LANE_ENABLE:   lane_enable   <= cfg_data[7:0];
        plbe_pkg::REG_INVERT_MASK:   invert_mask   <= cfg_data[7:0];
        plbe_pkg::REG_BIT_PERIOD_NS: bit_period_ns <= cfg_data[plbe_pkg::PERIOD_W-1:0];
        plbe_pkg::REG_LATCH_US:      latch_us      <= cfg_data[plbe_pkg::LATCH_US_W-1:0];
        default: ;
      endcase
    end
  end

  plbe_front #(.LANES(LANES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .lane_bytes  (lane_bytes),
    .lane_valid  (lane_valid),
    .lane_enable (lane_enable),
    .q_wr        (q_wr),
    .q_data      (q_wr_data),
    .q_full      (q_full)
  );

  plbe_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  plbe_div u_div (
    .clk           (clk),
    .rst           (rst),
    .restart       (div_restart),
    .bit_period_ns (bit_period_ns),
    .latch_us      (latch_us),
    .status        (div_status)
  );

  plbe_back #(.LANES(LANES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_rd_data),
    .q_rd        (q_rd),
    .invert_mask (invert_mask),
    .div_status  (div_status),
    .empty       (empty),
    .pop         (pop),
    .cell_word   (cell_word),
    .is_reset    (is_reset),
    .reset_cells (reset_cells),
    .last        (last)
  );

endmodule

/* sv/plbe_checker.sv */
// Port-level checks for the parallel LED bit-cell encoder, bound to the top level.
module plbe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           empty,
  input logic                           pop,
  input logic [plbe_pkg::CELL_W-1:0]    cell_word,
  input logic                           is_reset,
  input logic [plbe_pkg::CELLS_W-1:0]   reset_cells,
  input logic                           last
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_reset_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_reset) |-> last)
    else $error("A reset-gap item is not marked last.");

  a_cell_no_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_reset) |-> ((reset_cells == '0) &&
      (cell_word[15:8] == cell_word[23:16])))
    else $error("A bit-cell item carries a reset cell count or unequal data steps.");

  a_reset_idle_level: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_reset) |-> (cell_word[7:0] == cell_word[15:8] &&
      cell_word[15:8] == cell_word[23:16] && cell_word[23:16] == cell_word[31:24]))
    else $error("A reset-gap item does not hold the idle level in all steps.");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(cell_word) && $stable(last)))
    else $error("A waiting result item changed while stalled.");

endmodule

bind parallel_led_bit_cell_encoder_unit plbe_checker u_plbe_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .cell_word   (cell_word),
  .is_reset    (is_reset),
  .reset_cells (reset_cells),
  .last        (last)
);

/* dv/parallel_led_bit_cell_encoder_unit_tb.sv */
// Self-checking testbench for the parallel LED bit-cell encoder with a cell predictor.
module parallel_led_bit_cell_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LANES        = 8;
  localparam int          CW           = plbe_pkg::CELL_W;
  localparam int          NW           = plbe_pkg::CELLS_W;
  localparam int          IDX_W        = plbe_pkg::CFG_INDEX_W;
  localparam int          DAT_W        = plbe_pkg::CFG_DATA_W;
  localparam logic [7:0]  LANE_LIMIT   = 8'((1 << LANES) - 1);
  localparam logic        CMD_DATA     = 1'b0;
  localparam logic        CMD_EOF      = 1'b1;
  localparam int          SETTLE_CYC   = 40;
  localparam int          HOLD_CYC     = 200;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          RANDOM_PHASES = 5;
  localparam int          ITEMS_PER_PHASE = 40;

  typedef struct packed {
    logic [CW-1:0]  word;
    logic           gap;
    logic [NW-1:0]  cells;
    logic           last;
  } cell_t;

  class cell_scoreboard;
    logic [7:0]                          lane_en;
    logic [7:0]                          inv_mask;
    logic [plbe_pkg::PERIOD_W-1:0]       period_ns;
    logic [plbe_pkg::LATCH_US_W-1:0]     gap_us;
    cell_t                               cells_due[$];
    int                                  errors;

    function new();
      lane_en   = plbe_pkg::LANE_ENABLE_RST;
      inv_mask  = plbe_pkg::INVERT_MASK_RST;
      period_ns = plbe_pkg::BIT_PERIOD_RST;
      gap_us    = plbe_pkg::LATCH_US_RST;
      errors    = 0;
    endfunction

    function void note_config(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] data);
      case (idx)
        plbe_pkg::REG_LANE_ENABLE:   lane_en   = data[7:0];
        plbe_pkg::REG_INVERT_MASK:   inv_mask  = data[7:0];
        plbe_pkg::REG_BIT_PERIOD_NS: period_ns = data[plbe_pkg::PERIOD_W-1:0];
        plbe_pkg::REG_LATCH_US:      gap_us    = data[plbe_pkg::LATCH_US_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic cmd, logic [63:0] bytes, logic [7:0] valid);
      logic [CW-1:0]     idle_word;
      logic [7:0]        mask;
      logic [7:0]        ones;
      int unsigned       gap_len;
      cell_t             c;
      idle_word = {plbe_pkg::CELL_STEPS{inv_mask}};
      if (cmd == CMD_EOF) begin
        gap_len = (int'(gap_us) * plbe_pkg::US_TO_NS) / (int'(period_ns) + 1);
        c.word  = idle_word;
        c.gap   = 1'b1;
        c.cells = gap_len[NW-1:0];
        c.last  = 1'b1;
        cells_due.push_back(c);
        return;
      end
      mask = valid & lane_en & LANE_LIMIT;
      if (mask == 8'h00) return;
      for (int b = 0; b < 8; b++) begin
        ones = 8'h00;
        for (int k = 0; k < 8; k++) begin
          if (mask[k]) ones[k] = bytes[8*k + 7 - b];
        end
        c.word  = {8'h00, ones, ones, mask} ^ idle_word;
        c.gap   = 1'b0;
        c.cells = '0;
        c.last  = (b == 7);
        cells_due.push_back(c);
      end
    endfunction

    function void check_cell(logic [CW-1:0] word, logic gap, logic [NW-1:0] cells,
                             logic lst);
      cell_t exp_c;
      if (cells_due.size() == 0) begin
        $error("result with no item waiting: cell_word %h", word);
        errors++;
        return;
      end
      exp_c = cells_due.pop_front();
      if (word !== exp_c.word) begin
        $error("cell_word expected %h actual %h", exp_c.word, word);
        errors++;
      end
      if (gap !== exp_c.gap) begin
        $error("is_reset expected %b actual %b", exp_c.gap, gap);
        errors++;
      end
      if (cells !== exp_c.cells) begin
        $error("reset_cells expected %0d actual %0d", exp_c.cells, cells);
        errors++;
      end
      if (lst !== exp_c.last) begin
        $error("last expected %b actual %b", exp_c.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return cells_due.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic                   command = CMD_DATA;
  logic [63:0]            lane_bytes = '0;
  logic [7:0]             lane_valid = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [CW-1:0]          cell_word;
  logic                   is_reset;
  logic [NW-1:0]          reset_cells;
  logic                   last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index = plbe_pkg::REG_LANE_ENABLE;
  logic [DAT_W-1:0]       cfg_data = '0;

  cell_scoreboard sb = new();
  bit             idle_on = 1'b1;
  bit             hold_req = 1'b0;
  int             quiet_cycles = 0;

  parallel_led_bit_cell_encoder_unit #(.LANES(LANES)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .command(command), .lane_bytes(lane_bytes), .lane_valid(lane_valid),
    .empty(empty), .pop(pop),
    .cell_word(cell_word), .is_reset(is_reset), .reset_cells(reset_cells), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: checks every popped cell and throttles pop.
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_cell(cell_word, is_reset, reset_cells, last);
      if (hold_req) begin
        hold = HOLD_CYC;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [63:0] bytes, input logic [7:0] valid);
    push       <= 1'b1;
    command    <= cmd;
    lane_bytes <= bytes;
    lane_valid <= valid;
    do @(posedge clk); while (full);
    sb.note_item(cmd, bytes, valid);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [7:0] valid;
    case ($urandom_range(0, 7))
      0:       valid = 8'h00;
      1:       valid = 8'hFF;
      default: valid = 8'($urandom);
    endcase
    send_item(($urandom_range(0, 6) == 0) ? CMD_EOF : CMD_DATA, {$urandom, $urandom}, valid);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  task automatic configure(input logic [DAT_W-1:0] en, input logic [DAT_W-1:0] inv,
                           input logic [DAT_W-1:0] per, input logic [DAT_W-1:0] us);
    cfg_write(plbe_pkg::REG_LANE_ENABLE, en);
    cfg_write(plbe_pkg::REG_INVERT_MASK, inv);
    cfg_write(plbe_pkg::REG_BIT_PERIOD_NS, per);
    cfg_write(plbe_pkg::REG_LATCH_US, us);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DAT_W-1:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values: no lane enabled, default gap length.
    send_item(CMD_DATA, {$urandom, $urandom}, 8'hFF);
    send_item(CMD_EOF, {$urandom, $urandom}, 8'($urandom));
    drain();

    configure(16'h00FF, 16'h0000, 16'd1250, 16'd300);
    send_item(CMD_DATA, 64'h0, 8'hFF);
    send_item(CMD_DATA, '1, 8'hFF);
    send_item(CMD_DATA, 64'h55AA_33CC_0FF0_8001, 8'h0F);
    send_item(CMD_DATA, '1, 8'h00);
    send_item(CMD_DATA, {$urandom, $urandom}, 8'h80);
    send_item(CMD_DATA, {$urandom, $urandom}, 8'h01);
    send_item(CMD_EOF, {$urandom, $urandom}, 8'($urandom));
    send_item(CMD_DATA, {$urandom, $urandom}, 8'($urandom));
    drain();

    // Unused upper data bits, full inversion, shortest period, longest gap.
    configure(16'hFF5A, 16'h12FF, 16'd0, 16'hFFFF);
    send_item(CMD_EOF, '1, 8'hFF);
    send_item(CMD_DATA, '1, 8'hA5);
    send_item(CMD_DATA, {$urandom, $urandom}, 8'hFF);
    drain();

    configure(16'h00FF, 16'h003C, 16'hFFFF, 16'd0);
    send_item(CMD_EOF, 64'h0, 8'h00);
    send_item(CMD_DATA, {$urandom, $urandom}, 8'hFF);
    drain();

    configure(16'h00FF, 16'h00C3, 16'hFFFF, 16'd1023);
    send_item(CMD_EOF, {$urandom, $urandom}, 8'($urandom));
    send_item(CMD_DATA, {$urandom, $urandom}, 8'hFF);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != RANDOM_PHASES - 1);
      configure(($urandom_range(0, 2) == 0) ? 16'h00FF : 16'($urandom), 16'($urandom),
                pick_period(), 16'($urandom));
      if (p == 2) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
